// File: src/bief_pkg.sv
// Shared types and constants for the binary image Euler feature block.
package bief_pkg;

  localparam int CFG_W       = 11;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 136;

  localparam int FACE_W    = 21;
  localparam int EDGE_W    = 23;
  localparam int CONTACT_W = 22;
  localparam int TETRA_W   = 21;
  localparam int VERT_W    = 23;
  localparam int HOLE_W    = 22;
  localparam int PAD_W     = OUT_TDATA_W - FACE_W - EDGE_W - CONTACT_W - TETRA_W - VERT_W
                             - HOLE_W;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 11'd1024;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic pixel;
    logic row_nz;
    logic last_col;
    logic last_row;
  } pix_flags_t;

endpackage

// File: src/bief_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bief_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bief_fifo.sv
// Short queue between the pixel classifier and the feature accumulator.
module bief_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/bief_front.sv
// Configuration registers and raster position tracking for incoming pixels.
module bief_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bief_pkg::APB_AW-1:0]        paddr,
  input  logic [bief_pkg::APB_DW-1:0]        pwdata,
  output logic [bief_pkg::APB_DW-1:0]        prdata,
  output logic                               pready,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bief_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               push_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       col_o,
  output bief_pkg::pix_flags_t               flags_o,
  input  logic                               full_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CWP = $clog2(MAX_WIDTH + 1);
  localparam int RWP = $clog2(MAX_HEIGHT + 1);
  localparam int SWC = (CWP > bief_pkg::CFG_W) ? CWP : bief_pkg::CFG_W;
  localparam int SWR = (RWP > bief_pkg::CFG_W) ? RWP : bief_pkg::CFG_W;

  logic [bief_pkg::CFG_W-1:0] width_q, height_q;
  logic [SWC-1:0]             w_eff;
  logic [SWR-1:0]             h_eff;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic                       last_col, last_row, accept, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bief_pkg::REG_FRAME_HEIGHT) ?
                  bief_pkg::APB_DW'(height_q) : bief_pkg::APB_DW'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bief_pkg::FRAME_SIZE_RESET;
      height_q <= bief_pkg::FRAME_SIZE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bief_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[bief_pkg::CFG_W-1:0];
        bief_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[bief_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = SWC'(1);
    end else if (SWC'(width_q) > SWC'(MAX_WIDTH)) begin
      w_eff = SWC'(MAX_WIDTH);
    end else begin
      w_eff = SWC'(width_q);
    end
    if (height_q == '0) begin
      h_eff = SWR'(1);
    end else if (SWR'(height_q) > SWR'(MAX_HEIGHT)) begin
      h_eff = SWR'(MAX_HEIGHT);
    end else begin
      h_eff = SWR'(height_q);
    end
  end

  assign last_col      = (SWC'(col_q) + SWC'(1)) >= w_eff;
  assign last_row      = (SWR'(row_q) + SWR'(1)) >= h_eff;
  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign push_o           = accept;
  assign col_o            = col_q;
  assign flags_o.pixel    = s_axis_tdata[0];
  assign flags_o.row_nz   = (row_q != '0);
  assign flags_o.last_col = last_col;
  assign flags_o.last_row = last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (!last_col) begin
        col_d = col_q + CW'(1);
      end else begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: src/bief_back.sv
// Line buffer, feature counters and result formatting.
module bief_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             head_valid_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     head_col_i,
  input  bief_pkg::pix_flags_t             head_flags_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bief_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);

  logic                           run, pop;
  logic                           s1_v_q;
  logic [CW-1:0]                  s1_col_q;
  bief_pkg::pix_flags_t           s1_q;
  logic                           hit_q, byp_q, vld_q;
  logic                           rdata;
  logic [FW-1:0]                  fill_q;
  logic                           left_q, diag_q;
  logic                           up, left, ul, p, frame_end;
  logic [2:0]                     edges;
  logic [bief_pkg::FACE_W-1:0]    face_q, face_d;
  logic [bief_pkg::EDGE_W-1:0]    edge_q, edge_d;
  logic [bief_pkg::TETRA_W-1:0]   tetra_q, tetra_d;
  logic                           snap_v_q;
  logic [bief_pkg::FACE_W-1:0]    snap_f_q;
  logic [bief_pkg::EDGE_W-1:0]    snap_p_q;
  logic [bief_pkg::TETRA_W-1:0]   snap_t_q;
  logic                           out_v_q;
  logic [bief_pkg::EDGE_W-1:0]    four_f_minus_p;
  logic [bief_pkg::CONTACT_W-1:0] contact;
  logic [bief_pkg::VERT_W-1:0]    vert;
  logic [bief_pkg::HOLE_W-1:0]    hole;
  logic [bief_pkg::OUT_TDATA_W-1:0] out_q;

  assign run   = !out_v_q || m_axis_tready;
  assign pop   = run && head_valid_i;
  assign pop_o = pop;

  bief_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (run && s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_q.pixel),
    .re_i    (pop),
    .raddr_i (head_col_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (run) begin
      s1_v_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_col_q <= head_col_i;
      s1_q     <= head_flags_i;
      hit_q    <= s1_v_q && (s1_col_q == head_col_i);
      byp_q    <= s1_q.pixel;
      vld_q    <= FW'(head_col_i) < fill_q;
    end
  end

  assign p         = s1_q.pixel;
  assign up        = s1_q.row_nz && (hit_q ? byp_q : (vld_q && rdata));
  assign left      = (s1_col_q != '0) && left_q;
  assign ul        = (s1_col_q != '0) && diag_q;
  assign frame_end = s1_q.last_col && s1_q.last_row;
  assign edges     = 3'(p != left) + 3'(p != up) + 3'(p && s1_q.last_col)
                     + 3'(p && s1_q.last_row);
  assign face_d    = face_q + bief_pkg::FACE_W'(p);
  assign edge_d    = edge_q + bief_pkg::EDGE_W'(edges);
  assign tetra_d   = tetra_q + bief_pkg::TETRA_W'(p && up && left && ul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      left_q   <= 1'b0;
      diag_q   <= 1'b0;
      face_q   <= '0;
      edge_q   <= '0;
      tetra_q  <= '0;
      snap_v_q <= 1'b0;
    end else if (run) begin
      snap_v_q <= s1_v_q && frame_end;
      if (s1_v_q) begin
        left_q <= p;
        diag_q <= up;
        if (frame_end) begin
          fill_q  <= '0;
          face_q  <= '0;
          edge_q  <= '0;
          tetra_q <= '0;
        end else begin
          if (FW'(s1_col_q) == fill_q) begin
            fill_q <= fill_q + FW'(1);
          end
          face_q  <= face_d;
          edge_q  <= edge_d;
          tetra_q <= tetra_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && s1_v_q && frame_end) begin
      snap_f_q <= face_d;
      snap_p_q <= edge_d;
      snap_t_q <= tetra_d;
    end
  end

  assign four_f_minus_p = {snap_f_q, 2'b00} - snap_p_q;
  assign contact        = four_f_minus_p[bief_pkg::EDGE_W-1:1];
  assign vert           = bief_pkg::VERT_W'(snap_t_q) + snap_p_q;
  assign hole           = bief_pkg::HOLE_W'(snap_f_q)
                          - snap_p_q[bief_pkg::EDGE_W-1:1]
                          + bief_pkg::HOLE_W'(1)
                          - bief_pkg::HOLE_W'(snap_t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (run) begin
      out_v_q <= snap_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && snap_v_q) begin
      out_q <= {{bief_pkg::PAD_W{1'b0}}, hole, vert, snap_t_q, contact, snap_p_q, snap_f_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: src/binary_image_euler_features_core.sv
// Top level of the binary image Euler feature block.
//
// Pixels enter on the s_axis stream, one bit per word in raster order over a
// frame of frame_width by frame_height pixels set through the APB port
// (frame_width at byte address 0, frame_height at 4; 0 acts as 1, sizes above
// the maximum act as the maximum). The user must write sizes only while no
// frame result is pending; the block does not enforce this.
// After the last pixel of a frame one word leaves on m_axis with face count,
// outline perimeter, contact perimeter, tetrapixel count, vertex count and
// hole count; the counters then restart for the next frame.
// One pixel is taken every cycle while s_axis_tready is high. m_axis_tvalid
// follows the last pixel through line buffer read, snapshot and output register.
// The line buffer is a single RAM with one read and one write per cycle.
// Reset clears position, counters and line buffer contents (the buffer through
// a fill count, so no clearing pass is needed); sizes return to 1024.
// When the receiver stalls the result word holds in the output register, the
// pipeline behind it halts and the two-entry input queue fills before tready
// drops.
module binary_image_euler_features_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bief_pkg::APB_AW-1:0]      paddr,
  input  logic [bief_pkg::APB_DW-1:0]      pwdata,
  output logic [bief_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel
  input  logic [bief_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // face_count, boundary_edges, shared_edges, tetrapixel_count,
  // vertex_count, hole_count
  output logic [bief_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(bief_pkg::pix_flags_t);

  logic                 push, full, pop, head_valid;
  logic [CW-1:0]        col, head_col;
  bief_pkg::pix_flags_t flags, head_flags;
  logic [QW-1:0]        head_word;

  bief_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .col_o         (col),
    .flags_o       (flags),
    .full_i        (full)
  );

  bief_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({col, flags}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_word)
  );

  assign head_col   = head_word[QW-1 -: CW];
  assign head_flags = head_word[$bits(bief_pkg::pix_flags_t)-1:0];

  bief_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_col_i    (head_col),
    .head_flags_i  (head_flags),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: src/bief_checker.sv
// Port-level checks on the result stream of the Euler feature block.
module bief_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bief_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [20:0] face;
  logic [22:0] perim;
  logic [21:0] contact;
  logic [20:0] tetra;
  logic [22:0] vert;
  logic [22:0] four_f_minus_p;

  assign face           = m_axis_tdata[20:0];
  assign perim          = m_axis_tdata[43:21];
  assign contact        = m_axis_tdata[65:44];
  assign tetra          = m_axis_tdata[86:66];
  assign vert           = m_axis_tdata[109:87];
  assign four_f_minus_p = {face, 2'b00} - perim;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> vert == (23'(tetra) + perim))
    else $error("vertex count does not match tetrapixels plus perimeter");

  a_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> contact == four_f_minus_p[22:1])
    else $error("contact perimeter does not match faces and perimeter");

endmodule

bind binary_image_euler_features_core bief_checker u_bief_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: bench/euler_feature_checker.sv
// Checker for the Euler feature block: predicts and compares result words.
module euler_feature_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [bief_pkg::APB_AW-1:0]      paddr,
  input  logic [bief_pkg::APB_DW-1:0]      pwdata,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // pixel
  input  logic [bief_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // face_count, boundary_edges, shared_edges, tetrapixel_count,
  // vertex_count, hole_count
  input  logic [bief_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int                               pending_o,
  output int                               failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [bief_pkg::HOLE_W-1:0] hole_count;
    logic [bief_pkg::VERT_W-1:0]        vertex_count;
    logic [bief_pkg::TETRA_W-1:0]       tetrapixel_count;
    logic [bief_pkg::CONTACT_W-1:0]     shared_edges;
    logic [bief_pkg::EDGE_W-1:0]        boundary_edges;
    logic [bief_pkg::FACE_W-1:0]        face_count;
  } euler_result_t;

  logic [bief_pkg::CFG_W-1:0]   width_cfg = bief_pkg::FRAME_SIZE_RESET;
  logic [bief_pkg::CFG_W-1:0]   height_cfg = bief_pkg::FRAME_SIZE_RESET;
  logic                         row_store [MAX_WIDTH];
  logic                         left_px = 1'b0;
  logic                         diag_px = 1'b0;
  int unsigned                  col_idx = 0;
  int unsigned                  row_idx = 0;
  logic [bief_pkg::FACE_W-1:0]  face_tot = '0;
  logic [bief_pkg::EDGE_W-1:0]  edge_tot = '0;
  logic [bief_pkg::TETRA_W-1:0] window_tot = '0;
  euler_result_t                frame_results_q[$];
  int                           fail_total = 0;

  function automatic int unsigned clamp_size(input logic [bief_pkg::CFG_W-1:0] v,
                                             input int unsigned limit);
    if (v == '0) return 1;
    if (32'(v) > limit) return limit;
    return 32'(v);
  endfunction

  function automatic string fmt_result(input euler_result_t r);
    return $sformatf("F=%0d P=%0d C=%0d T=%0d V=%0d H=%0d", r.face_count,
                     r.boundary_edges, r.shared_edges, r.tetrapixel_count,
                     r.vertex_count, r.hole_count);
  endfunction

  task automatic clear_frame_state();
    foreach (row_store[i]) row_store[i] = 1'b0;
    left_px    = 1'b0;
    diag_px    = 1'b0;
    col_idx    = 0;
    row_idx    = 0;
    face_tot   = '0;
    edge_tot   = '0;
    window_tot = '0;
  endtask

  task automatic take_pixel(input logic pix);
    int unsigned   w, h, col, row, edges;
    logic          up, lft, ul, last_col, last_row;
    logic [63:0]   f, pe, t, contact, verts, holes;
    euler_result_t r;
    w        = clamp_size(width_cfg, MAX_WIDTH);
    h        = clamp_size(height_cfg, MAX_HEIGHT);
    col      = col_idx;
    row      = row_idx;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
    up    = (row > 0) ? row_store[col] : 1'b0;
    lft   = (col > 0) ? left_px : 1'b0;
    ul    = (col > 0) ? diag_px : 1'b0;
    edges = 0;
    if (pix != lft) edges++;
    if (pix != up) edges++;
    if (pix && last_col) edges++;
    if (pix && last_row) edges++;
    face_tot = face_tot + bief_pkg::FACE_W'(pix);
    edge_tot = edge_tot + bief_pkg::EDGE_W'(edges);
    if (pix && up && lft && ul) window_tot = window_tot + 1'b1;
    diag_px        = up;
    left_px        = pix;
    row_store[col] = pix;
    if (!last_col) begin
      col_idx = col + 1;
      return;
    end
    col_idx = 0;
    left_px = 1'b0;
    diag_px = 1'b0;
    if (!last_row) begin
      row_idx = row + 1;
      return;
    end
    f       = 64'(face_tot);
    pe      = 64'(edge_tot);
    t       = 64'(window_tot);
    contact = (4 * f - pe) >> 1;
    verts   = t + pe;
    holes   = f - (pe >> 1) + 1 - t;
    r.face_count       = face_tot;
    r.boundary_edges   = edge_tot;
    r.shared_edges     = contact[bief_pkg::CONTACT_W-1:0];
    r.tetrapixel_count = window_tot;
    r.vertex_count     = verts[bief_pkg::VERT_W-1:0];
    r.hole_count       = holes[bief_pkg::HOLE_W-1:0];
    frame_results_q.push_back(r);
    clear_frame_state();
  endtask

  task automatic check_result();
    euler_result_t got, want;
    got = m_axis_tdata[$bits(euler_result_t)-1:0];
    if (frame_results_q.size() == 0) begin
      if (fail_total < 10) $display("%0t: unexpected result %s", $realtime, fmt_result(got));
      fail_total++;
      return;
    end
    want = frame_results_q.pop_front();
    if (got !== want) begin
      if (fail_total < 10) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg  = bief_pkg::FRAME_SIZE_RESET;
      height_cfg = bief_pkg::FRAME_SIZE_RESET;
      clear_frame_state();
      frame_results_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bief_pkg::REG_FRAME_WIDTH) width_cfg = pwdata[bief_pkg::CFG_W-1:0];
        else height_cfg = pwdata[bief_pkg::CFG_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) check_result();
      pending_o  <= frame_results_q.size();
      failures_o <= fail_total;
    end
  end

endmodule

// File: bench/binary_image_euler_features_core_tb.sv
// Testbench top for the Euler feature block: stimulus, result stalls and verdict.
module binary_image_euler_features_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH        = 1024;
  localparam int MAX_HEIGHT       = 1024;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int ITEM_TARGET      = 1250;
  localparam int LONG_HOLD_AFTER  = 6;
  localparam int LONG_HOLD_CYCLES = 300;

  localparam logic [bief_pkg::APB_AW-1:0] ADDR_FRAME_WIDTH  =
    {bief_pkg::REG_FRAME_WIDTH, 2'b00};
  localparam logic [bief_pkg::APB_AW-1:0] ADDR_FRAME_HEIGHT =
    {bief_pkg::REG_FRAME_HEIGHT, 2'b00};

  typedef enum int {
    IMG_NOISE,
    IMG_SOLID,
    IMG_BLANK,
    IMG_RING,
    IMG_CHECKER,
    IMG_DIAGONAL
  } image_kind_e;

  typedef enum int {
    PACE_FULL,
    PACE_RANDOM,
    PACE_SPARSE
  } pace_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [bief_pkg::APB_AW-1:0]      paddr = '0;
  logic [bief_pkg::APB_DW-1:0]      pwdata = '0;
  logic [bief_pkg::APB_DW-1:0]      prdata;
  logic                             pready;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // pixel
  logic [bief_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // face_count, boundary_edges, shared_edges, tetrapixel_count,
  // vertex_count, hole_count
  logic [bief_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  int    pending;
  int    failures;
  int    cycle_count = 0;
  int    items_sent = 0;
  pace_e send_pace = PACE_FULL;

  binary_image_euler_features_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  euler_feature_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .pending_o    (pending),
    .failures_o   (failures)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(input pace_e pace);
    case (pace)
      PACE_RANDOM: return $urandom_range(0, 18);
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      default:     return 0;
    endcase
  endfunction

  function automatic int eff_size(input int v, input int limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  task automatic write_reg(input logic [bief_pkg::APB_AW-1:0] addr, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= bief_pkg::APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    wait_drained();
    write_reg(ADDR_FRAME_WIDTH, w);
    write_reg(ADDR_FRAME_HEIGHT, h);
  endtask

  task automatic send_pixel(input logic pix);
    int gap;
    gap = draw_gap(send_pace);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bief_pkg::IN_TDATA_W'(pix);
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_frame(input int w, input int h, input image_kind_e kind, input int density);
    logic pix;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (kind)
          IMG_SOLID:    pix = 1'b1;
          IMG_BLANK:    pix = 1'b0;
          IMG_RING:     pix = (r == 0 || c == 0 || r == h - 1 || c == w - 1);
          IMG_CHECKER:  pix = ((r + c) % 2 == 0);
          IMG_DIAGONAL: pix = (r == c);
          default:      pix = ($urandom_range(0, 99) < density);
        endcase
        send_pixel(pix);
      end
    end
  endtask

  initial begin
    int          stall, taken;
    pace_e       pace;
    taken = 0;
    pace  = PACE_FULL;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 11) == 0) pace = pace_e'($urandom_range(0, 2));
      stall = (taken == LONG_HOLD_AFTER) ? LONG_HOLD_CYCLES : draw_gap(pace);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    int          phase, w, h, frames, sel, density;
    image_kind_e kind;
    phase = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_frame(0, 0);
    send_frame(1, 1, IMG_SOLID, 0);
    send_frame(1, 1, IMG_BLANK, 0);
    set_frame(3, 3);
    send_frame(3, 3, IMG_SOLID, 0);
    send_frame(3, 3, IMG_RING, 0);
    set_frame(2, 2);
    send_frame(2, 2, IMG_DIAGONAL, 0);

    set_frame(1, 1);
    for (int i = 0; i < 24; i++) send_pixel(1'($urandom_range(0, 1)));

    while (items_sent < ITEM_TARGET) begin
      frames = $urandom_range(2, 5);
      case (phase)
        2: begin
          w      = 2047;
          h      = 1;
          frames = 1;
        end
        default: begin
          sel = $urandom_range(0, 99);
          if (sel < 70) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
          end else if (sel < 85) begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 5);
          end else if (sel < 95) begin
            w = $urandom_range(1, 3);
            h = $urandom_range(9, 40);
          end else begin
            w = 0;
            h = $urandom_range(0, 4);
          end
        end
      endcase
      set_frame(w, h);
      send_pace = pace_e'($urandom_range(0, 2));
      for (int f = 0; f < frames; f++) begin
        sel     = $urandom_range(0, 99);
        density = $urandom_range(10, 90);
        if (sel < 60) kind = IMG_NOISE;
        else if (sel < 70) kind = IMG_SOLID;
        else if (sel < 78) kind = IMG_BLANK;
        else if (sel < 88) kind = IMG_RING;
        else if (sel < 95) kind = IMG_CHECKER;
        else kind = IMG_DIAGONAL;
        send_frame(eff_size(w, MAX_WIDTH), eff_size(h, MAX_HEIGHT), kind, density);
      end
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bief_pkg.sv
src/bief_ram.sv
src/bief_fifo.sv
src/bief_front.sv
src/bief_back.sv
src/binary_image_euler_features_core.sv
src/bief_checker.sv
bench/euler_feature_checker.sv
bench/binary_image_euler_features_core_tb.sv
